// ----- hdl/gmb_pkg.sv -----
// ----------------------------------------------------------------------------
// gmb_pkg
// Shared types and constants for the greedy meshlet builder.
// ----------------------------------------------------------------------------
`default_nettype none

package gmb_pkg;

  // Table depth and triangle limit of one meshlet.
  localparam int MAX_VERTS = 64;
  localparam int MAX_PRIMS = 126;

  // Width of a local vertex index into the table.
  localparam int IDX_W = $clog2(MAX_VERTS);

  // Fixed field widths.
  localparam int CNT_W     = 7;
  localparam int VID_W     = 32;
  localparam int OFS_W     = 32;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int LOC_W     = 10;

  // Lower clamps of the configured limits.
  localparam int VLIM_MIN = 3;
  localparam int PLIM_MIN = 1;

  // Record kinds.
  localparam logic [KIND_W-1:0] REC_MESHLET = 2'd0;
  localparam logic [KIND_W-1:0] REC_VERTEX  = 2'd1;
  localparam logic [KIND_W-1:0] REC_PRIM    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VERTICES   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PRIMITIVES = 1'd1;

  // Hit flags of one table lane, one per triangle corner.
  typedef struct packed {
    logic [2:0] hit;
  } lane_hit_t;

  // Merged lookup result for the three corners.
  typedef struct packed {
    logic [2:0]            found;
    logic [2:0][IDX_W-1:0] idx;
  } merge_t;

  // Sequencer states.
  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_LOOK    = 7'b0000010,
    S_PLAN    = 7'b0000100,
    S_CLOSE_A = 7'b0001000,
    S_VERT    = 7'b0010000,
    S_PRIM    = 7'b0100000,
    S_CLOSE_B = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/greedy_meshlet_builder.sv -----
// ----------------------------------------------------------------------------
// Sequence: a triangle is captured in idle, compared in the lookup cycle and
// planned, then passes an optional close, three vertex slots (a vertex record
// for each new corner), the primitive and an optional end-of-mesh close; a
// degenerate one goes from the plan back to idle or to that close. A new
// triangle is taken only in idle. Output stalls hold the record steps.
// Reset: synchronous, active low; clears counts, offsets and the output valid,
// and sets the limits to 64 and 126.
// ----------------------------------------------------------------------------
// greedy_meshlet_builder
// Groups a stream of triangles into meshlets under vertex and triangle limits.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_meshlet_builder (
  input  wire                               clk,
  input  wire                               rst_n,
  // Configuration write channel.
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [gmb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [gmb_pkg::CNT_W-1:0]         cfg_data,
  // Triangle input channel.
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [gmb_pkg::VID_W-1:0]         in_vertex_a,
  input  wire  [gmb_pkg::VID_W-1:0]         in_vertex_b,
  input  wire  [gmb_pkg::VID_W-1:0]         in_vertex_c,
  input  wire                               in_end_of_mesh,
  // Record output channel.
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [gmb_pkg::KIND_W-1:0]        out_record_kind,
  output logic [gmb_pkg::VID_W-1:0]         out_payload,
  output logic [gmb_pkg::CNT_W-1:0]         out_meshlet_vertex_count,
  output logic [gmb_pkg::CNT_W-1:0]         out_meshlet_primitive_count,
  output logic [gmb_pkg::OFS_W-1:0]         out_meshlet_vertex_offset,
  output logic [gmb_pkg::OFS_W-1:0]         out_meshlet_primitive_offset,
  output logic                              out_last
);

  // --------------------------------------------------------------------------
  // The vertex table is a row of lanes. Each lane holds one unique global
  // index of the open meshlet and compares it with all three corners of the
  // captured triangle in the lookup cycle. The merge stage registers which
  // corners were found and where. The plan cycle then drops a degenerate
  // triangle or decides whether the open meshlet must be closed first, and the
  // sequencer walks through the records one per cycle while the output is free:
  // optional close, one slot per corner (a vertex record for each new corner),
  // the packed primitive, and the optional end-of-mesh close.
  // --------------------------------------------------------------------------

  localparam int IDX_W = gmb_pkg::IDX_W;
  localparam int CNT_W = gmb_pkg::CNT_W;
  localparam int VID_W = gmb_pkg::VID_W;
  localparam int OFS_W = gmb_pkg::OFS_W;

  // Control state.
  gmb_pkg::state_t     state_r, state_nxt;
  logic [CNT_W-1:0]    vc_r, vc_nxt;
  logic [CNT_W-1:0]    pc_r, pc_nxt;
  logic [OFS_W-1:0]    vo_r, vo_nxt;
  logic [OFS_W-1:0]    po_r, po_nxt;
  logic [CNT_W-1:0]    maxv_r, maxv_nxt;
  logic [CNT_W-1:0]    maxp_r, maxp_nxt;
  logic [1:0]          slot_r, slot_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Item data, no reset needed.
  logic [2:0][VID_W-1:0]  key_r, key_nxt;
  logic                   eom_r, eom_nxt;
  logic [2:0]             new_r, new_nxt;
  logic [2:0][IDX_W-1:0]  local_r, local_nxt;

  // Output register.
  logic [gmb_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [VID_W-1:0]           pay_r, pay_nxt;
  logic [CNT_W-1:0]           ovc_r, ovc_nxt;
  logic [CNT_W-1:0]           opc_r, opc_nxt;
  logic [OFS_W-1:0]           ovo_r, ovo_nxt;
  logic [OFS_W-1:0]           opo_r, opo_nxt;
  logic                       last_r, last_nxt;

  // Lanes and merge.
  gmb_pkg::lane_hit_t [gmb_pkg::MAX_VERTS-1:0] hits;
  gmb_pkg::merge_t                             merged;
  logic                                        tbl_wr;
  logic [VID_W-1:0]                            tbl_data;

  // Plan-cycle helpers.
  logic [CNT_W-1:0]   vlim, plim;
  logic [1:0]         found_cnt;
  logic [CNT_W:0]     need_v;
  logic               degen;
  logic               close_first;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != gmb_pkg::S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------- lanes
  for (genvar i = 0; i < gmb_pkg::MAX_VERTS; i++) begin : g_lane
    gmb_lane u_lane (
      .clk     (clk),
      .wr_en   (tbl_wr && (vc_r[IDX_W-1:0] == IDX_W'(i))),
      .wr_data (tbl_data),
      .active  (CNT_W'(i) < vc_r),
      .keys    (key_r),
      .hits    (hits[i])
    );
  end

  gmb_merge u_merge (
    .clk      (clk),
    .hits     (hits),
    .result_r (merged)
  );

  // A new corner is written at the fill count while its record goes out.
  assign tbl_wr   = (state_r == gmb_pkg::S_VERT) && new_r[slot_r] && out_free
                    && (vc_r < CNT_W'(gmb_pkg::MAX_VERTS));
  assign tbl_data = key_r[slot_r];

  // ------------------------------------------------------- plan arithmetic
  always_comb begin
    if (maxv_r < CNT_W'(gmb_pkg::VLIM_MIN)) begin
      vlim = CNT_W'(gmb_pkg::VLIM_MIN);
    end else if (maxv_r > CNT_W'(gmb_pkg::MAX_VERTS)) begin
      vlim = CNT_W'(gmb_pkg::MAX_VERTS);
    end else begin
      vlim = maxv_r;
    end
    if (maxp_r < CNT_W'(gmb_pkg::PLIM_MIN)) begin
      plim = CNT_W'(gmb_pkg::PLIM_MIN);
    end else if (maxp_r > CNT_W'(gmb_pkg::MAX_PRIMS)) begin
      plim = CNT_W'(gmb_pkg::MAX_PRIMS);
    end else begin
      plim = maxp_r;
    end
    found_cnt = 2'(merged.found[0]) + 2'(merged.found[1]) + 2'(merged.found[2]);
    need_v    = {1'b0, vc_r} + (CNT_W+1)'(3) - (CNT_W+1)'(found_cnt);
    degen     = (key_r[0] == key_r[1]) || (key_r[0] == key_r[2])
                || (key_r[1] == key_r[2]);
    close_first = (need_v > {1'b0, vlim})
                  || (({1'b0, pc_r} + (CNT_W+1)'(1)) > {1'b0, plim});
  end

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_nxt     = state_r;
    vc_nxt        = vc_r;
    pc_nxt        = pc_r;
    vo_nxt        = vo_r;
    po_nxt        = po_r;
    maxv_nxt      = maxv_r;
    maxp_nxt      = maxp_r;
    slot_nxt      = slot_r;
    key_nxt       = key_r;
    eom_nxt       = eom_r;
    new_nxt       = new_r;
    local_nxt     = local_r;
    kind_nxt      = kind_r;
    pay_nxt       = pay_r;
    ovc_nxt       = ovc_r;
    opc_nxt       = opc_r;
    ovo_nxt       = ovo_r;
    opo_nxt       = opo_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gmb_pkg::CFG_MAX_VERTICES:   maxv_nxt = cfg_data;
        gmb_pkg::CFG_MAX_PRIMITIVES: maxp_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      gmb_pkg::S_IDLE: begin
        if (in_valid) begin
          key_nxt   = {in_vertex_c, in_vertex_b, in_vertex_a};
          eom_nxt   = in_end_of_mesh;
          state_nxt = gmb_pkg::S_LOOK;
        end
      end

      // The lanes compare; the merge stage registers the outcome.
      gmb_pkg::S_LOOK: begin
        state_nxt = gmb_pkg::S_PLAN;
      end

      gmb_pkg::S_PLAN: begin
        local_nxt = merged.idx;
        slot_nxt  = 2'd0;
        if (degen) begin
          state_nxt = (eom_r && (vc_r != '0)) ? gmb_pkg::S_CLOSE_B : gmb_pkg::S_IDLE;
        end else if (close_first) begin
          // After the close the table is empty, so every corner is new.
          new_nxt   = 3'b111;
          state_nxt = gmb_pkg::S_CLOSE_A;
        end else begin
          new_nxt   = ~merged.found;
          state_nxt = gmb_pkg::S_VERT;
        end
      end

      gmb_pkg::S_CLOSE_A, gmb_pkg::S_CLOSE_B: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = gmb_pkg::REC_MESHLET;
          pay_nxt       = '0;
          ovc_nxt       = vc_r;
          opc_nxt       = pc_r;
          ovo_nxt       = vo_r;
          opo_nxt       = po_r;
          last_nxt      = (state_r == gmb_pkg::S_CLOSE_B);
          vo_nxt        = vo_r + OFS_W'(vc_r);
          po_nxt        = po_r + OFS_W'(pc_r);
          vc_nxt        = '0;
          pc_nxt        = '0;
          state_nxt     = (state_r == gmb_pkg::S_CLOSE_B) ? gmb_pkg::S_IDLE
                                                          : gmb_pkg::S_VERT;
        end
      end

      // One corner per cycle, a new one only while the output is free; a corner that is already present only passes.
      gmb_pkg::S_VERT: begin
        if (!new_r[slot_r] || out_free) begin
          if (new_r[slot_r]) begin
            out_valid_nxt      = 1'b1;
            kind_nxt           = gmb_pkg::REC_VERTEX;
            pay_nxt            = key_r[slot_r];
            ovc_nxt            = '0;
            opc_nxt            = '0;
            ovo_nxt            = '0;
            opo_nxt            = '0;
            last_nxt           = 1'b0;
            local_nxt[slot_r]  = vc_r[IDX_W-1:0];
            vc_nxt             = vc_r + CNT_W'(1);
          end
          if (slot_r == 2'd2) begin
            slot_nxt  = 2'd0;
            state_nxt = gmb_pkg::S_PRIM;
          end else begin
            slot_nxt  = slot_r + 2'd1;
          end
        end
      end

      // The meshlet is never empty here, so end of mesh always closes it.
      gmb_pkg::S_PRIM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = gmb_pkg::REC_PRIM;
          pay_nxt       = {2'b00,
                           gmb_pkg::LOC_W'(local_r[2]),
                           gmb_pkg::LOC_W'(local_r[1]),
                           gmb_pkg::LOC_W'(local_r[0])};
          ovc_nxt       = '0;
          opc_nxt       = '0;
          ovo_nxt       = '0;
          opo_nxt       = '0;
          last_nxt      = !eom_r;
          pc_nxt        = pc_r + CNT_W'(1);
          state_nxt     = eom_r ? gmb_pkg::S_CLOSE_B : gmb_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = gmb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gmb_pkg::S_IDLE;
      vc_r        <= '0;
      pc_r        <= '0;
      vo_r        <= '0;
      po_r        <= '0;
      maxv_r      <= CNT_W'(gmb_pkg::MAX_VERTS);
      maxp_r      <= CNT_W'(gmb_pkg::MAX_PRIMS);
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vc_r        <= vc_nxt;
      pc_r        <= pc_nxt;
      vo_r        <= vo_nxt;
      po_r        <= po_nxt;
      maxv_r      <= maxv_nxt;
      maxp_r      <= maxp_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    eom_r   <= eom_nxt;
    new_r   <= new_nxt;
    local_r <= local_nxt;
    kind_r  <= kind_nxt;
    pay_r   <= pay_nxt;
    ovc_r   <= ovc_nxt;
    opc_r   <= opc_nxt;
    ovo_r   <= ovo_nxt;
    opo_r   <= opo_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid                    = out_valid_r;
  assign out_record_kind              = kind_r;
  assign out_payload                  = pay_r;
  assign out_meshlet_vertex_count     = ovc_r;
  assign out_meshlet_primitive_count  = opc_r;
  assign out_meshlet_vertex_offset    = ovo_r;
  assign out_meshlet_primitive_offset = opo_r;
  assign out_last                     = last_r;

endmodule

`default_nettype wire

// ----- hdl/gmb_lane.sv -----
// ----------------------------------------------------------------------------
// gmb_lane
// One entry of the vertex table with its three key comparators.
// ----------------------------------------------------------------------------
`default_nettype none

module gmb_lane (
  input  wire                                  clk,
  input  wire                                  wr_en,
  input  wire  [gmb_pkg::VID_W-1:0]            wr_data,
  input  wire                                  active,
  input  wire  [2:0][gmb_pkg::VID_W-1:0]       keys,
  output gmb_pkg::lane_hit_t                   hits
);

  logic [gmb_pkg::VID_W-1:0] entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_data;
    end
  end

  // An entry at or above the fill count never matches.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hits.hit[k] = active && (entry_r == keys[k]);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/gmb_merge.sv -----
// ----------------------------------------------------------------------------
// gmb_merge
// Combines the lane hits into a found flag and a local index per corner.
// ----------------------------------------------------------------------------
`default_nettype none

module gmb_merge (
  input  wire                                            clk,
  input  wire gmb_pkg::lane_hit_t [gmb_pkg::MAX_VERTS-1:0] hits,
  output gmb_pkg::merge_t                                result_r
);

  gmb_pkg::merge_t result_nxt;

  // Table entries are unique, so at most one lane hits per corner and the
  // index can be formed by OR-ing the lane numbers.
  always_comb begin
    result_nxt = '0;
    for (int i = 0; i < gmb_pkg::MAX_VERTS; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (hits[i].hit[k]) begin
          result_nxt.found[k] = 1'b1;
          result_nxt.idx[k]   = result_nxt.idx[k] | gmb_pkg::IDX_W'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/gmb_checker.sv -----
// ----------------------------------------------------------------------------
// gmb_checker
// Port-level checks of the greedy meshlet builder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gmb_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_valid,
  input wire                            in_stall,
  input wire                            out_valid,
  input wire                            out_stall,
  input wire [gmb_pkg::KIND_W-1:0]      out_record_kind,
  input wire [gmb_pkg::VID_W-1:0]       out_payload,
  input wire [gmb_pkg::CNT_W-1:0]       out_meshlet_vertex_count,
  input wire [gmb_pkg::CNT_W-1:0]       out_meshlet_primitive_count,
  input wire [gmb_pkg::OFS_W-1:0]       out_meshlet_vertex_offset,
  input wire [gmb_pkg::OFS_W-1:0]       out_meshlet_primitive_offset,
  input wire                            out_last
);

  // A stalled item keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload)
                               && $stable(out_record_kind) && $stable(out_last))
    else $error("stalled output item changed");

  // The block works on one triangle at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is at work");

  // A closed meshlet always holds at least one whole triangle.
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_record_kind == gmb_pkg::REC_MESHLET)
      |-> (out_meshlet_vertex_count >= gmb_pkg::CNT_W'(3))
          && (out_meshlet_primitive_count != '0))
    else $error("empty meshlet closed");

  // Vertex and primitive items carry zero meshlet fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_record_kind != gmb_pkg::REC_MESHLET)
      |-> (out_meshlet_vertex_count == '0) && (out_meshlet_primitive_count == '0)
          && (out_meshlet_vertex_offset == '0)
          && (out_meshlet_primitive_offset == '0))
    else $error("meshlet fields set on a non-meshlet item");

endmodule

bind greedy_meshlet_builder gmb_checker u_gmb_checker (
  .clk                          (clk),
  .rst_n                        (rst_n),
  .in_valid                     (in_valid),
  .in_stall                     (in_stall),
  .out_valid                    (out_valid),
  .out_stall                    (out_stall),
  .out_record_kind              (out_record_kind),
  .out_payload                  (out_payload),
  .out_meshlet_vertex_count     (out_meshlet_vertex_count),
  .out_meshlet_primitive_count  (out_meshlet_primitive_count),
  .out_meshlet_vertex_offset    (out_meshlet_vertex_offset),
  .out_meshlet_primitive_offset (out_meshlet_primitive_offset),
  .out_last                     (out_last)
);

`default_nettype wire
